@@ rtl/core/sha_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 engine.
package sha_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned WinDepth  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_DATA,
    PH_DATA_LAST,
    PH_PAD,
    PH_LENHI,
    PH_LENLO
  } phase_e;

  typedef enum logic [2:0] {
    REG_RAW_MODE = 3'd0,
    REG_ROUNDS   = 3'd1,
    REG_SV01     = 3'd2,
    REG_SV23     = 3'd3,
    REG_SV45     = 3'd4,
    REG_SV67     = 3'd5
  } reg_idx_e;

  localparam logic [31:0] StdIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

@@ rtl/core/sha_if.sv @@
// Valid/ready stream interfaces for message items and digest items.
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_of_digest;
  logic        length_error;

  modport source (output valid, digest_word, word_index, last_of_digest, length_error,
                  input ready);
  modport sink   (input valid, digest_word, word_index, last_of_digest, length_error,
                  output ready);
endinterface

@@ rtl/core/sha256_hash_engine.sv @@
// SHA-256 engine top level: sequencer, round unit, schedule window, APB registers.
// Message words enter on in_ch; each item is one big-endian word, and the word marked
// last closes the message, after which eight digest items leave on out_ch (index 0..7).
// In standard mode the engine pads the message and hashes from the fixed IV; in raw mode
// (register 0) it compresses exactly one 64-byte block from the start value in registers
// 2..5 for round_count rounds, and a raw message of any other length yields eight zero
// words with length_error set. One shared round unit runs one round per cycle; a
// compression holds the round state for its rounds and one more step in which the count
// only reaches its limit, then a feed-forward step adds the working state into the chain.
// In standard mode each word is accepted and then appended to the window, and a word
// that fills the block starts a compression. A raw word that is not last is only
// accepted. A standard last word also appends the padding words one by one with one or
// two compressions; any last word then leads to digest output, longer when out_ch stalls.
// in_ch.ready is high only while the engine is idle. Registers sit on a 64-bit APB port,
// register i at byte address 8*i; writes are meant only while the engine is idle.
module sha256_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha_in_if.sink      in_ch,
  sha_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // configuration
  logic        raw_q;
  logic [6:0]  rc_q;
  logic [63:0] sv_q [4];

  // message control
  sha_pkg::state_e state_q, state_d, ret_q, ret_d;
  sha_pkg::phase_e ph_q;
  logic [63:0] blen_q;
  logic [4:0]  wib_q;
  logic [6:0]  rnd_q, lim_q;
  logic [2:0]  idx_q;
  logic        err_q;
  logic [31:0] app_q;

  // datapath
  logic [31:0] chain_q [8];
  logic [31:0] work_q  [8];
  logic [31:0] win_q   [16];

  logic        in_acc, out_acc, cfg_wr;
  logic [2:0]  nb;
  logic [63:0] blen_n;
  logic [4:0]  wib_n, wib_inc;
  logic        raw_ok;
  logic [31:0] pad_word;
  logic [31:0] w_new, t1, t2, ch, mj;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // ---------------- APB registers ----------------
  always_comb begin
    prdata = '0;
    unique case (paddr[5:3])
      sha_pkg::REG_RAW_MODE: prdata = {63'd0, raw_q};
      sha_pkg::REG_ROUNDS:   prdata = {57'd0, rc_q};
      sha_pkg::REG_SV01:     prdata = sv_q[0];
      sha_pkg::REG_SV23:     prdata = sv_q[1];
      sha_pkg::REG_SV45:     prdata = sv_q[2];
      sha_pkg::REG_SV67:     prdata = sv_q[3];
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= 1'b0;
      rc_q  <= 7'd64;
      for (int i = 0; i < 4; i++) sv_q[i] <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        sha_pkg::REG_RAW_MODE: raw_q <= pwdata[0];
        sha_pkg::REG_ROUNDS:   rc_q  <= (pwdata[6:0] > 7'd64) ? 7'd64 : pwdata[6:0];
        sha_pkg::REG_SV01:     sv_q[0] <= pwdata;
        sha_pkg::REG_SV23:     sv_q[1] <= pwdata;
        sha_pkg::REG_SV45:     sv_q[2] <= pwdata;
        sha_pkg::REG_SV67:     sv_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // ---------------- item decode ----------------
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // only a last word may carry fewer than four bytes; 5..7 count as four
  assign nb = (!in_ch.last_word || in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
  assign blen_n  = blen_q + {58'd0, nb, 3'b000};
  assign wib_inc = wib_q + 5'd1;
  // raw words past the sixteenth are counted but not stored
  assign wib_n   = (nb != 3'd0 && wib_q < 5'd16) ? wib_inc : wib_q;
  assign raw_ok  = (blen_n == 64'd512) && (wib_n == 5'd16);

  // partial last word: keep valid bytes, then the 0x80 marker byte
  always_comb begin
    case (nb[1:0])
      2'd0:    pad_word = 32'h8000_0000;
      2'd1:    pad_word = {in_ch.message_word[31:24], 24'h80_0000};
      2'd2:    pad_word = {in_ch.message_word[31:16], 16'h8000};
      default: pad_word = {in_ch.message_word[31:8], 8'h80};
    endcase
  end

  // ---------------- round unit ----------------
  assign w_new = sha_pkg::ssig1(win_q[14]) + win_q[9] + sha_pkg::ssig0(win_q[1]) + win_q[0];
  assign ch    = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign mj    = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1    = work_q[7] + sha_pkg::bsig1(work_q[4]) + ch
               + sha_pkg::RoundK[rnd_q[5:0]] + win_q[0];
  assign t2    = sha_pkg::bsig0(work_q[0]) + mj;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!raw_q) begin
            state_d = sha_pkg::ST_APPEND;
          end else if (in_ch.last_word) begin
            state_d = raw_ok ? sha_pkg::ST_ROUND : sha_pkg::ST_OUT;
            ret_d   = sha_pkg::ST_OUT;
          end
        end
      end
      sha_pkg::ST_APPEND: begin
        if (wib_q == 5'd16) begin
          // window left full by raw words: compress it first
          state_d = sha_pkg::ST_ROUND;
          ret_d   = sha_pkg::ST_APPEND;
        end else begin
          unique case (ph_q)
            sha_pkg::PH_DATA:  ret_d = sha_pkg::ST_IDLE;
            sha_pkg::PH_LENLO: ret_d = sha_pkg::ST_OUT;
            default:           ret_d = sha_pkg::ST_APPEND;
          endcase
          state_d = (wib_inc == 5'd16) ? sha_pkg::ST_ROUND : ret_d;
        end
      end
      sha_pkg::ST_ROUND: if (rnd_q == lim_q) state_d = sha_pkg::ST_FEED;
      sha_pkg::ST_FEED:  state_d = ret_q;
      sha_pkg::ST_OUT:   if (out_acc && idx_q == 3'd7) state_d = sha_pkg::ST_IDLE;
      default:           state_d = sha_pkg::ST_IDLE;
    endcase
  end

  // ---------------- handshake outputs ----------------
  always_comb begin
    in_ch.ready           = (state_q == sha_pkg::ST_IDLE);
    out_ch.valid          = (state_q == sha_pkg::ST_OUT);
    out_ch.digest_word    = err_q ? 32'd0 : chain_q[idx_q];
    out_ch.word_index     = idx_q;
    out_ch.last_of_digest = (idx_q == 3'd7);
    out_ch.length_error   = err_q;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      ret_q   <= sha_pkg::ST_IDLE;
      ph_q    <= sha_pkg::PH_DATA;
      blen_q  <= '0;
      wib_q   <= '0;
      rnd_q   <= '0;
      lim_q   <= 7'd64;
      idx_q   <= '0;
      err_q   <= 1'b0;
      for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::StdIv[i];
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      unique case (state_q)
        sha_pkg::ST_IDLE: begin
          if (in_acc) begin
            idx_q <= '0;
            rnd_q <= '0;
            if (raw_q) begin
              wib_q  <= wib_n;
              blen_q <= blen_n;
              err_q  <= !raw_ok;
              lim_q  <= rc_q;
              if (in_ch.last_word && raw_ok) begin
                for (int i = 0; i < 4; i++) begin
                  chain_q[2*i]   <= sv_q[i][63:32];
                  chain_q[2*i+1] <= sv_q[i][31:0];
                end
              end
            end else begin
              err_q  <= 1'b0;
              lim_q  <= 7'd64;
              blen_q <= blen_n;
              if (nb == 3'd4) begin
                ph_q <= in_ch.last_word ? sha_pkg::PH_DATA_LAST : sha_pkg::PH_DATA;
              end else begin
                ph_q <= sha_pkg::PH_PAD;
              end
            end
          end
        end
        sha_pkg::ST_APPEND: begin
          rnd_q <= '0;
          if (wib_q != 5'd16) begin
            wib_q <= wib_inc;
            unique case (ph_q)
              sha_pkg::PH_DATA_LAST: ph_q <= sha_pkg::PH_PAD;
              sha_pkg::PH_PAD: if (wib_inc == 5'd14) ph_q <= sha_pkg::PH_LENHI;
              sha_pkg::PH_LENHI: ph_q <= sha_pkg::PH_LENLO;
              default: ;
            endcase
          end
        end
        sha_pkg::ST_ROUND: if (rnd_q != lim_q) rnd_q <= rnd_q + 7'd1;
        sha_pkg::ST_FEED: begin
          wib_q <= '0;
          for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + work_q[i];
        end
        sha_pkg::ST_OUT: begin
          if (out_acc) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              // message done: back to the standard start
              blen_q <= '0;
              wib_q  <= '0;
              for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::StdIv[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (raw_q) begin
            if (nb != 3'd0 && wib_q < 5'd16) begin
              for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
              win_q[15] <= in_ch.message_word;
            end
            for (int i = 0; i < 4; i++) begin
              work_q[2*i]   <= sv_q[i][63:32];
              work_q[2*i+1] <= sv_q[i][31:0];
            end
          end else begin
            app_q <= (nb == 3'd4) ? in_ch.message_word : pad_word;
          end
        end
      end
      sha_pkg::ST_APPEND: begin
        for (int i = 0; i < 8; i++) work_q[i] <= chain_q[i];
        if (wib_q != 5'd16) begin
          for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
          win_q[15] <= app_q;
          unique case (ph_q)
            sha_pkg::PH_DATA_LAST: app_q <= 32'h8000_0000;
            sha_pkg::PH_PAD:       app_q <= (wib_inc == 5'd14) ? blen_q[63:32] : 32'd0;
            sha_pkg::PH_LENHI:     app_q <= blen_q[31:0];
            default: ;
          endcase
        end
      end
      sha_pkg::ST_ROUND: begin
        if (rnd_q != lim_q) begin
          for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
          win_q[15] <= w_new;
          work_q[7] <= work_q[6];
          work_q[6] <= work_q[5];
          work_q[5] <= work_q[4];
          work_q[4] <= work_q[3] + t1;
          work_q[3] <= work_q[2];
          work_q[2] <= work_q[1];
          work_q[1] <= work_q[0];
          work_q[0] <= t1 + t2;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while digest pending");
  a_wib_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wib_q <= 5'd16)
    else $error("block word count out of range");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha_pkg::ST_ROUND) |-> (rnd_q <= lim_q && lim_q <= 7'd64))
    else $error("round counter past limit");
  a_digest_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && idx_q == 3'd7) |=> in_ch.ready)
    else $error("engine not idle after last digest item");
`endif

endmodule

@@ tb/tb_sha256_hash_engine.sv @@
// Self-checking testbench for the SHA-256 hash engine in standard and raw block modes.
`timescale 1ns / 1ps

module tb_sha256_hash_engine;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_of_digest;
    logic        length_error;
  } digest_item_t;

  // Directed row: one message word; pin_word0 set pins digest word 0 to known_word.
  typedef struct {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
    logic        pin_word0;
    logic [31:0] known_word;
  } msg_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  sha_in_if  in_ch();
  sha_out_if out_ch();

  sha256_hash_engine dut (
    .clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Predicted engine state and register copy.
  logic        mdl_raw;
  int unsigned mdl_rounds;
  logic [63:0] mdl_start [4];
  logic [31:0] mdl_chain [8];
  logic [31:0] mdl_win [16];
  logic [63:0] mdl_bits;
  int unsigned mdl_fill;

  digest_item_t digest_q[$];
  int unsigned  mismatches = 0;
  int unsigned  words_sent = 0;
  bit           steady = 1'b0;  // no idling on either side while set

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block(int unsigned n);
    logic [31:0] v [8];
    logic [31:0] w, w2, w15, t1, t2, ep, ap;
    v = mdl_chain;
    for (int unsigned t = 0; t < n && t < 64; t++) begin
      if (t < 16) begin
        w = mdl_win[t];
      end else begin
        w2  = mdl_win[(t - 2) & 15];
        w15 = mdl_win[(t - 15) & 15];
        w = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + mdl_win[(t - 7) & 15]
            + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + mdl_win[t & 15];
        mdl_win[t & 15] = w;
      end
      ep = v[4];
      ap = v[0];
      t1 = v[7] + (rotr(ep, 6) ^ rotr(ep, 11) ^ rotr(ep, 25))
           + ((ep & v[5]) ^ (~ep & v[6])) + sha_pkg::RoundK[t] + w;
      t2 = (rotr(ap, 2) ^ rotr(ap, 13) ^ rotr(ap, 22))
           + ((ap & v[1]) ^ (ap & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) mdl_chain[i] += v[i];
  endfunction

  function automatic void block_append(logic [31:0] w);
    if (mdl_fill >= 16) begin
      compress_block(64);
      mdl_fill = 0;
    end
    mdl_win[mdl_fill] = w;
    mdl_fill++;
    if (mdl_fill == 16) begin
      compress_block(64);
      mdl_fill = 0;
    end
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) mdl_chain[i] = sha_pkg::StdIv[i];
    mdl_bits = '0;
    mdl_fill = 0;
  endfunction

  // Works out the digest items that one accepted word causes.
  function automatic void predict_digest(logic [31:0] w, logic [2:0] vb, logic lst);
    int unsigned nb;
    logic        err;
    logic [31:0] keep;
    digest_item_t it;
    nb  = (!lst || vb > 4) ? 4 : vb;
    err = 1'b0;
    if (mdl_raw) begin
      if (nb > 0) begin
        if (mdl_fill < 16) begin
          mdl_win[mdl_fill] = w;
          mdl_fill++;
        end
        mdl_bits += 64'(nb * 8);
      end
      if (!lst) return;
      if (mdl_bits == 64'd512 && mdl_fill == 16) begin
        for (int i = 0; i < 4; i++) begin
          mdl_chain[2 * i]     = mdl_start[i][63:32];
          mdl_chain[2 * i + 1] = mdl_start[i][31:0];
        end
        compress_block(mdl_rounds);
      end else begin
        err = 1'b1;
      end
    end else begin
      if (nb == 4) begin
        block_append(w);
        mdl_bits += 64'd32;
      end
      if (!lst) return;
      if (nb == 4) begin
        block_append(32'h8000_0000);
      end else begin
        keep = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
        block_append((w & keep) | (32'h80 << (24 - 8 * nb)));
        mdl_bits += 64'(nb * 8);
      end
      while (mdl_fill != 14) block_append(32'h0);
      block_append(mdl_bits[63:32]);
      block_append(mdl_bits[31:0]);
    end
    for (int i = 0; i < 8; i++) begin
      it.digest_word    = err ? 32'h0 : mdl_chain[i];
      it.word_index     = 3'(i);
      it.last_of_digest = (i == 7);
      it.length_error   = err;
      digest_q.push_back(it);
    end
    restart_hash();
  endfunction

  // Digest sink: random back-pressure, compare each accepted item with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    digest_item_t exp_it;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest item: word %h index %0d", out_ch.digest_word,
                   out_ch.word_index);
      end else begin
        exp_it = digest_q.pop_front();
        if (out_ch.digest_word !== exp_it.digest_word ||
            out_ch.word_index !== exp_it.word_index ||
            out_ch.last_of_digest !== exp_it.last_of_digest ||
            out_ch.length_error !== exp_it.length_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                     exp_it.digest_word, exp_it.word_index, exp_it.last_of_digest,
                     exp_it.length_error, out_ch.digest_word, out_ch.word_index,
                     out_ch.last_of_digest, out_ch.length_error);
        end
      end
    end
  end

  // Sender: random idle gaps, hold valid until ready is seen, predict on acceptance.
  // valid stays up after acceptance so the next word can follow with no gap.
  task automatic send_word(logic [31:0] w, logic [2:0] vb, logic lst);
    while (!steady && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_word <= w;
    in_ch.valid_bytes  <= vb;
    in_ch.last_word    <= lst;
    forever begin
      @(negedge clk_i);
      if (in_ch.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    predict_digest(w, vb, lst);
    words_sent++;
  endtask

  // Words before the last may carry any byte count; it is ignored there.
  task automatic send_message(int unsigned nwords, logic [2:0] last_vb);
    for (int unsigned i = 1; i < nwords; i++)
      send_word($urandom(), ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
    send_word($urandom(), last_vb, 1'b1);
  endtask

  // Wait until the engine is idle: nothing expected, and a block compression's worth more.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(sha_pkg::reg_idx_e r, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(r) << 3;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      sha_pkg::REG_RAW_MODE: mdl_raw = val[0];
      sha_pkg::REG_ROUNDS:   mdl_rounds = (val[6:0] > 64) ? 64 : val[6:0];
      default:               mdl_start[int'(r) - int'(sha_pkg::REG_SV01)] = val;
    endcase
  endtask

  task automatic write_start_value(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                   logic [63:0] d);
    write_reg(sha_pkg::REG_SV01, a);
    write_reg(sha_pkg::REG_SV23, b);
    write_reg(sha_pkg::REG_SV45, c);
    write_reg(sha_pkg::REG_SV67, d);
  endtask

  // Standard-mode directed rows: empty and short messages, byte counts, padding spill.
  msg_row_t std_rows [] = '{
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'he3b0c442},   // empty message
    '{32'h6162_6300, 3'd3, 1'b1, 1'b1, 32'hba7816bf},   // "abc"
    '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0000, 3'd7, 1'b1, 1'b0, 32'h0},          // oversized count acts as 4
    '{32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0, 32'h0},
    '{32'hA5A5_A5A5, 3'd5, 1'b1, 1'b0, 32'h0},
    '{32'h8000_0000, 3'd6, 1'b1, 1'b0, 32'h0},
    '{32'h1234_5678, 3'd1, 1'b0, 1'b0, 32'h0},          // partial count on a non-last word
    '{32'h9ABC_DEF0, 3'd2, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0001, 3'd0, 1'b0, 1'b0, 32'h0},
    '{32'hDEAD_BEEF, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h0F0F_0F0F, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'hF0F0_F0F0, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h0000_FFFF, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_0000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0001, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h0123_4567, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h89AB_CDEF, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'hFEDC_BA98, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h7654_3210, 3'd4, 1'b1, 1'b0, 32'h0}           // 14 words: padding spills a block
  };

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.message_word = '0;
    in_ch.valid_bytes  = '0;
    in_ch.last_word    = 1'b0;
    mdl_raw    = 1'b0;
    mdl_rounds = 64;
    for (int i = 0; i < 4; i++) mdl_start[i] = '0;
    for (int i = 0; i < 16; i++) mdl_win[i] = '0;
    restart_hash();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed standard mode; pinned rows override word 0 with the known digest.
    foreach (std_rows[i]) begin
      send_word(std_rows[i].message_word, std_rows[i].valid_bytes, std_rows[i].last_word);
      if (std_rows[i].pin_word0)
        digest_q[digest_q.size() - 8].digest_word = std_rows[i].known_word;
    end

    // Random standard-mode messages, a stretch of them without idling.
    while (words_sent < 70) begin
      steady = (words_sent > 20 && words_sent < 55);
      send_message(($urandom_range(99) < 80) ? $urandom_range(1, 18) : $urandom_range(19, 40),
                   3'($urandom_range(7)));
    end
    steady = 1'b0;
    drain();

    // Raw mode directed: good block, short, overflow, trailing empty last, zero rounds.
    write_reg(sha_pkg::REG_RAW_MODE, 64'd1);
    write_start_value({sha_pkg::StdIv[0], sha_pkg::StdIv[1]},
                      {sha_pkg::StdIv[2], sha_pkg::StdIv[3]},
                      {sha_pkg::StdIv[4], sha_pkg::StdIv[5]},
                      {sha_pkg::StdIv[6], sha_pkg::StdIv[7]});
    send_message(16, 3'd4);
    send_message(15, 3'd4);
    send_message(17, 3'd4);
    send_message(16, 3'd3);
    for (int i = 0; i < 16; i++) send_word($urandom(), 3'd4, 1'b0);
    send_word($urandom(), 3'd0, 1'b1);
    drain();
    write_reg(sha_pkg::REG_ROUNDS, 64'd0);
    write_start_value('0, '0, '0, '0);
    send_message(16, 3'd4);
    drain();

    // Raw mode across round counts and start values, extremes first.
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: write_reg(sha_pkg::REG_ROUNDS, 64'd127);
        1: write_reg(sha_pkg::REG_ROUNDS, 64'd1);
        2: write_reg(sha_pkg::REG_ROUNDS, 64'd64);
        3: write_reg(sha_pkg::REG_ROUNDS, 64'd65);
        default: write_reg(sha_pkg::REG_ROUNDS, 64'($urandom()));
      endcase
      if (s == 0) write_start_value('1, '1, '1, '1);
      else write_start_value({$urandom(), $urandom()}, {$urandom(), $urandom()},
                             {$urandom(), $urandom()}, {$urandom(), $urandom()});
      repeat (2) begin
        if ($urandom_range(99) < 80)
          send_message(16, ($urandom_range(1) == 0) ? 3'd4 : 3'($urandom_range(5, 7)));
        else
          send_message($urandom_range(1, 20), 3'($urandom_range(7)));
      end
      drain();
    end

    // Mode switched while a message is open: earlier words stay standard.
    write_reg(sha_pkg::REG_RAW_MODE, 64'd0);
    send_word($urandom(), 3'd4, 1'b0);
    send_word($urandom(), 3'd4, 1'b0);
    drain();
    write_reg(sha_pkg::REG_RAW_MODE, 64'd1);
    send_message(14, 3'd4);
    drain();
    write_reg(sha_pkg::REG_RAW_MODE, 64'd0);
    write_reg(sha_pkg::REG_ROUNDS, 64'd64);

    // Standard mode again up to the item budget.
    while (words_sent < 385) begin
      send_message($urandom_range(1, 24), 3'($urandom_range(7)));
    end

    drain();
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
